// File: rtl/core/pot_to_servo_duty_mapper_macros.svh
// Assertion macros shared by the servo duty mapper RTL.
`ifndef POT_TO_SERVO_DUTY_MAPPER_MACROS_SVH
`define POT_TO_SERVO_DUTY_MAPPER_MACROS_SVH

// Same-cycle implication, checked on every rising edge of clk outside reset.
`define PTSD_ASSERT_IMPLY(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge of clk outside reset.
`define PTSD_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// File: rtl/core/ptsd_pkg.sv
// Shared widths, constants and types of the servo duty mapper.
package ptsd_pkg;

    // Field and datapath widths.
    localparam int RAW_W     = 12;
    localparam int FRAC_W    = 16;
    localparam int LEVEL_W   = 28;
    localparam int ANGLE_W   = 8;
    localparam int DUTY_W    = 13;
    localparam int PULSE_W   = 15;
    localparam int TICK_W    = 14;
    localparam int NUM_W     = 23;
    localparam int DIV_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // Shared multiplier operand widths (both signed).
    localparam int MUL_A_W   = 30;
    localparam int MUL_B_W   = 24;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;

    // Smoothing weight in Q16 and the pot range that maps to full angle.
    localparam int ALPHA_Q16 = 9830;
    localparam int POT_LIMIT = 2730;

    // angle = level * 6 / 91 (same as level * 180 / 2730).
    localparam int ANG_SCALE = 6;
    localparam int ANG_DIV   = 91;
    localparam int ANG_RECIP = 11522;      // floor(2^20 / 91)
    localparam int ANG_SHIFT = 20;

    // ticks = us * 256 / 625 (same as us * 8192 / 20000).
    localparam int TICK_PRE   = 8;
    localparam int TICK_DIV   = 625;
    localparam int TICK_RECIP = 6871947;   // floor(2^32 / 625), applied to us
    localparam int TICK_SHIFT = 24;

    // Interpolation step: angle * span / 180.
    localparam int DUTY_DIV   = 180;
    localparam int DUTY_RECIP = 1491308;   // floor(2^28 / 180)
    localparam int DUTY_SHIFT = 28;
    localparam int DUTY_MAX   = 8191;
    localparam int DUTY_SUM_W = 15;

    // Register reset values.
    localparam int MIN_PULSE_RST = 1000;
    localparam int MAX_PULSE_RST = 2000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = 2'd1;

    // Sequencer states: each *_MUL issues a product, *_CHK takes the quotient
    // estimate and issues its back-multiply, *_FIX applies the correction.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EMA_MUL,
        ST_EMA_UPD,
        ST_ANG_MUL,
        ST_ANG_CHK,
        ST_ANG_FIX,
        ST_LO_MUL,
        ST_LO_CHK,
        ST_LO_FIX,
        ST_HI_MUL,
        ST_HI_CHK,
        ST_HI_FIX,
        ST_SPAN_MUL,
        ST_DUTY_MUL,
        ST_DUTY_CHK,
        ST_DUTY_FIX
    } ptsd_state_t;

endpackage

// File: rtl/core/ptsd_mul.sv
// Shared signed multiplier with a registered product.
module ptsd_mul
    import ptsd_pkg::*;
#(
    parameter int A_W = MUL_A_W,
    parameter int B_W = MUL_B_W
)
(
    input  logic                     clk,
    input  logic signed [A_W-1:0]    a,
    input  logic signed [B_W-1:0]    b,
    output logic signed [A_W+B_W-1:0] prod
);

    logic signed [A_W+B_W-1:0] prod_reg;

    // One product per cycle, registered before any use.
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// File: rtl/core/pot_to_servo_duty_mapper.sv
// Top level: potentiometer sample smoothing and servo duty mapping.
// A result is written to the output register in the last step of the sequence, ST_DUTY_FIX.
// A new sample is accepted only in idle, so samples never overlap in the single shared multiplier sequence.
// A sample whose angle matches the last emitted one returns to idle after the angle step with no result.
// The last step waits while an earlier result is still held on the output side.
// Reset (rst_n low, asynchronous) clears the average and last angle, sets pulses to 1000/2000 us.
`include "pot_to_servo_duty_mapper_macros.svh"

module pot_to_servo_duty_mapper
    import ptsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [11:0] raw_sample, rest zero
    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [7:0] angle_deg, [20:8] duty_ticks
    // Configuration writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [PULSE_W-1:0]    cfg_data
);

    // Control state.
    ptsd_state_t             state_reg, state_next;
    logic [PULSE_W-1:0]      min_pulse_reg, max_pulse_reg;
    logic [LEVEL_W-1:0]      level_reg, level_next;
    logic [ANGLE_W-1:0]      last_angle_reg;
    logic                    known_reg;
    logic                    out_valid_reg, out_valid_next;

    // Payload registers.
    logic [RAW_W-1:0]        raw_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [TICK_W-1:0]       q_reg;
    logic [ANGLE_W-1:0]      angle_reg;
    logic [TICK_W-1:0]       lo_reg, hi_reg;
    logic [ANGLE_W-1:0]      out_angle_reg;
    logic [DUTY_W-1:0]       out_duty_reg;

    // Datapath signals.
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [MUL_A_W-1:0] ema_diff, ema_step, ema_sum;
    logic [RAW_W-1:0]        pot_raw, pot_lvl;
    logic [TICK_W-1:0]       ang_num;
    logic [TICK_W-1:0]       span;
    logic [NUM_W-1:0]        rem;
    logic [DIV_W-1:0]        fix_div;
    logic [TICK_W-1:0]       q_fixed;
    logic [ANGLE_W-1:0]      angle_fixed;
    logic                    angle_same;
    logic [DUTY_SUM_W-1:0]   duty_sum;
    logic [DUTY_W-1:0]       duty_sat;
    logic                    in_xfer, out_free;

    // Shared multiplier.
    ptsd_mul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Handshake terms.
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_duty_reg, out_angle_reg};

    // Moving-average arithmetic: difference to target and floored Q16 step.
    assign ema_diff = $signed(MUL_A_W'({raw_reg, {FRAC_W{1'b0}}}))
                    - $signed(MUL_A_W'(level_reg));
    assign ema_step = prod[MUL_A_W+FRAC_W-1:FRAC_W];
    assign ema_sum  = $signed(MUL_A_W'(level_reg)) + ema_step;
    assign level_next = ema_sum[MUL_A_W-1] ? '0 : ema_sum[LEVEL_W-1:0];

    // Clamped integer level, scaled by six for the angle division.
    assign pot_raw = level_reg[LEVEL_W-1:FRAC_W];
    assign pot_lvl = (pot_raw > RAW_W'(POT_LIMIT)) ? RAW_W'(POT_LIMIT) : pot_raw;
    assign ang_num = TICK_W'({pot_lvl, 2'b00}) + TICK_W'({pot_lvl, 1'b0});

    // Pulse span, zero when the maximum lies below the minimum.
    assign span = (hi_reg >= lo_reg) ? (hi_reg - lo_reg) : '0;

    // Quotient correction: the estimate is exact or one low.
    assign rem         = num_reg - prod[NUM_W-1:0];
    assign q_fixed     = q_reg + TICK_W'(rem >= NUM_W'(fix_div));
    assign angle_fixed = q_fixed[ANGLE_W-1:0];
    assign angle_same  = known_reg && (angle_fixed == last_angle_reg);

    // Final duty with saturation to 13 bits.
    assign duty_sum = DUTY_SUM_W'(lo_reg) + DUTY_SUM_W'(q_fixed);
    assign duty_sat = (duty_sum > DUTY_SUM_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX)
                                                          : duty_sum[DUTY_W-1:0];

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     state_next = in_xfer ? ST_EMA_MUL : ST_IDLE;
            ST_EMA_MUL:  state_next = ST_EMA_UPD;
            ST_EMA_UPD:  state_next = ST_ANG_MUL;
            ST_ANG_MUL:  state_next = ST_ANG_CHK;
            ST_ANG_CHK:  state_next = ST_ANG_FIX;
            ST_ANG_FIX:  state_next = angle_same ? ST_IDLE : ST_LO_MUL;
            ST_LO_MUL:   state_next = ST_LO_CHK;
            ST_LO_CHK:   state_next = ST_LO_FIX;
            ST_LO_FIX:   state_next = ST_HI_MUL;
            ST_HI_MUL:   state_next = ST_HI_CHK;
            ST_HI_CHK:   state_next = ST_HI_FIX;
            ST_HI_FIX:   state_next = ST_SPAN_MUL;
            ST_SPAN_MUL: state_next = ST_DUTY_MUL;
            ST_DUTY_MUL: state_next = ST_DUTY_CHK;
            ST_DUTY_CHK: state_next = ST_DUTY_FIX;
            ST_DUTY_FIX: state_next = out_free ? ST_IDLE : ST_DUTY_FIX;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: multiplier operands and the correction divisor.
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        fix_div = '0;
        unique case (state_reg)
            ST_EMA_MUL:
            begin
                mul_a = ema_diff;
                mul_b = MUL_B_W'(ALPHA_Q16);
            end
            ST_ANG_MUL:
            begin
                mul_a = MUL_A_W'(ang_num);
                mul_b = MUL_B_W'(ANG_RECIP);
            end
            ST_ANG_CHK:
            begin
                mul_a = MUL_A_W'(prod[ANG_SHIFT+ANGLE_W-1:ANG_SHIFT]);
                mul_b = MUL_B_W'(ANG_DIV);
            end
            ST_ANG_FIX:
            begin
                fix_div = DIV_W'(ANG_DIV);
            end
            ST_LO_MUL:
            begin
                mul_a = MUL_A_W'(min_pulse_reg);
                mul_b = MUL_B_W'(TICK_RECIP);
            end
            ST_HI_MUL:
            begin
                mul_a = MUL_A_W'(max_pulse_reg);
                mul_b = MUL_B_W'(TICK_RECIP);
            end
            ST_LO_CHK, ST_HI_CHK:
            begin
                mul_a = MUL_A_W'(prod[TICK_SHIFT+TICK_W-1:TICK_SHIFT]);
                mul_b = MUL_B_W'(TICK_DIV);
            end
            ST_LO_FIX, ST_HI_FIX:
            begin
                fix_div = DIV_W'(TICK_DIV);
            end
            ST_SPAN_MUL:
            begin
                mul_a = MUL_A_W'(angle_reg);
                mul_b = MUL_B_W'(span);
            end
            ST_DUTY_MUL:
            begin
                mul_a = MUL_A_W'(prod[NUM_W-1:0]);
                mul_b = MUL_B_W'(DUTY_RECIP);
            end
            ST_DUTY_CHK:
            begin
                mul_a = MUL_A_W'(prod[DUTY_SHIFT+TICK_W-1:DUTY_SHIFT]);
                mul_b = MUL_B_W'(DUTY_DIV);
            end
            ST_DUTY_FIX:
            begin
                // Keep the back-product steady while the output side stalls.
                mul_a   = MUL_A_W'(q_reg);
                mul_b   = MUL_B_W'(DUTY_DIV);
                fix_div = DIV_W'(DUTY_DIV);
            end
            default:
            begin
                mul_a   = '0;
                mul_b   = '0;
                fix_div = '0;
            end
        endcase
    end

    // Output valid: held until the transfer, set when the last step finishes.
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        if ((state_reg == ST_DUTY_FIX) && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            min_pulse_reg  <= PULSE_W'(MIN_PULSE_RST);
            max_pulse_reg  <= PULSE_W'(MAX_PULSE_RST);
            level_reg      <= '0;
            last_angle_reg <= '0;
            known_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_MIN_PULSE: min_pulse_reg <= cfg_data;
                    REG_MAX_PULSE: max_pulse_reg <= cfg_data;
                    default:       ;
                endcase
            end
            if (state_reg == ST_EMA_UPD)
            begin
                level_reg <= level_next;
            end
            if ((state_reg == ST_ANG_FIX) && !angle_same)
            begin
                last_angle_reg <= angle_fixed;
                known_reg      <= 1'b1;
            end
        end
    end

    // Payload registers of the sequence.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            raw_reg <= s_axis_tdata[RAW_W-1:0];
        end
        unique case (state_reg)
            ST_ANG_MUL:  num_reg <= NUM_W'(ang_num);
            ST_LO_MUL:   num_reg <= NUM_W'({min_pulse_reg, {TICK_PRE{1'b0}}});
            ST_HI_MUL:   num_reg <= NUM_W'({max_pulse_reg, {TICK_PRE{1'b0}}});
            ST_DUTY_MUL: num_reg <= prod[NUM_W-1:0];
            ST_ANG_CHK:  q_reg <= TICK_W'(prod[ANG_SHIFT+ANGLE_W-1:ANG_SHIFT]);
            ST_LO_CHK, ST_HI_CHK:
                q_reg <= prod[TICK_SHIFT+TICK_W-1:TICK_SHIFT];
            ST_DUTY_CHK: q_reg <= prod[DUTY_SHIFT+TICK_W-1:DUTY_SHIFT];
            ST_ANG_FIX:  angle_reg <= angle_fixed;
            ST_LO_FIX:   lo_reg <= q_fixed;
            ST_HI_FIX:   hi_reg <= q_fixed;
            ST_DUTY_FIX:
            begin
                if (out_free)
                begin
                    out_angle_reg <= angle_reg;
                    out_duty_reg  <= duty_sat;
                end
            end
            default:     ;
        endcase
    end

    // Checks on the sequencer and the reciprocal divisions.
    `PTSD_ASSERT_IMPLY(a_ang_rem, state_reg == ST_ANG_FIX, rem < NUM_W'(2 * ANG_DIV), "angle quotient estimate off by more than one")
    `PTSD_ASSERT_IMPLY(a_tick_rem, (state_reg == ST_LO_FIX) || (state_reg == ST_HI_FIX), rem < NUM_W'(2 * TICK_DIV), "tick quotient estimate off by more than one")
    `PTSD_ASSERT_IMPLY(a_duty_rem, state_reg == ST_DUTY_FIX, rem < NUM_W'(2 * DUTY_DIV), "duty quotient estimate off by more than one")
    `PTSD_ASSERT_NEXT(a_start, in_xfer, state_reg == ST_EMA_MUL, "input transfer did not start the sequence")
    `PTSD_ASSERT_IMPLY(a_emit_src, $rose(m_axis_tvalid), $past(state_reg) == ST_DUTY_FIX, "result raised outside the final step")
    `PTSD_ASSERT_IMPLY(a_last_angle, known_reg, last_angle_reg <= ANGLE_W'(180), "stored angle out of range")

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the servo duty mapper: predicting scoreboard and stream drivers.
module tb_top;
    import ptsd_pkg::*;

    // Timing of the run.
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 160;
    localparam int NUM_PHASES    = 9;

    // Servo timing constants used by the duty prediction.
    localparam int unsigned PERIOD_US  = 20000;
    localparam int unsigned FULL_TICKS = 8192;
    localparam int unsigned FULL_ANGLE = 180;

    // Register indexes beyond the two real registers; writes to them are dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [DUTY_W-1:0]  duty;
    } servo_cmd_t;

    // Scoreboard that tracks the smoothed level and queues the servo commands it implies.
    class duty_scoreboard;
        int unsigned min_us;
        int unsigned max_us;
        longint      avg_q16;
        logic [ANGLE_W-1:0] last_angle;
        bit          angle_known;
        servo_cmd_t  pending_cmds[$];
        int unsigned samples_seen;
        int unsigned cmds_checked;
        int unsigned mismatches;

        function new();
            min_us      = MIN_PULSE_RST;
            max_us      = MAX_PULSE_RST;
            avg_q16     = 0;
            last_angle  = '0;
            angle_known = 1'b0;
        endfunction

        task report(string msg);
            mismatches++;
            $display("MISMATCH: %s", msg);
        endtask

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PULSE_W-1:0] val);
            if (idx == REG_MIN_PULSE)
                min_us = 32'(val);
            else if (idx == REG_MAX_PULSE)
                max_us = 32'(val);
        endfunction

        function int unsigned us_to_ticks(int unsigned us);
            return (us * FULL_TICKS) / PERIOD_US;
        endfunction

        // Advance the average by one sample and queue a command if the angle moved.
        function void note_sample(logic [RAW_W-1:0] raw);
            longint      gap_q16;
            longint      nxt;
            int unsigned whole;
            int unsigned ang;
            int unsigned lo;
            int unsigned hi;
            int unsigned span;
            int unsigned duty;
            servo_cmd_t  cmd;

            samples_seen++;
            gap_q16 = (longint'(raw) <<< FRAC_W) - avg_q16;
            nxt = avg_q16 + ((gap_q16 * ALPHA_Q16) >>> FRAC_W);
            if (nxt < 0)
                nxt = 0;
            avg_q16 = nxt & 64'h0FFF_FFFF;

            whole = 32'(avg_q16 >> FRAC_W);
            if (whole > POT_LIMIT)
                whole = POT_LIMIT;
            ang = (whole * FULL_ANGLE) / POT_LIMIT;
            if (angle_known && ang == 32'(last_angle))
                return;

            lo   = us_to_ticks(min_us);
            hi   = us_to_ticks(max_us);
            span = (hi >= lo) ? hi - lo : 0;
            duty = lo + (ang * span) / FULL_ANGLE;
            if (duty > DUTY_MAX)
                duty = DUTY_MAX;

            last_angle  = ANGLE_W'(ang);
            angle_known = 1'b1;
            cmd.angle   = ANGLE_W'(ang);
            cmd.duty    = DUTY_W'(duty);
            pending_cmds.push_back(cmd);
        endfunction

        // Compare one output transfer with the oldest queued command.
        task check_command(logic [M_TDATA_W-1:0] word);
            servo_cmd_t want;
            logic [ANGLE_W-1:0] got_angle;
            logic [DUTY_W-1:0]  got_duty;

            got_angle = word[ANGLE_W-1:0];
            got_duty  = word[ANGLE_W+DUTY_W-1:ANGLE_W];
            if (pending_cmds.size() == 0)
            begin
                report($sformatf("unexpected command angle %0d duty %0d", got_angle, got_duty));
                return;
            end
            want = pending_cmds.pop_front();
            cmds_checked++;
            if (got_angle !== want.angle)
                report($sformatf("angle got %0d expected %0d", got_angle, want.angle));
            if (got_duty !== want.duty)
                report($sformatf("duty got %0d expected %0d (angle %0d)",
                                 got_duty, want.duty, want.angle));
        endtask
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;   // [11:0] raw_sample, rest zero
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;         // [7:0] angle_deg, [20:8] duty_ticks
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PULSE_W-1:0]   cfg_data  = '0;

    duty_scoreboard sb = new();

    int unsigned quiet_cycles = 0;
    int unsigned reg_writes   = 0;
    bit          calm         = 1'b0;
    bit          gappy        = 1'b1;
    logic [RAW_W-1:0] prev_raw = '0;

    pot_to_servo_duty_mapper dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Watch every transfer; results are checked before the same edge's sample is noted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_command(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_sample(s_axis_tdata[RAW_W-1:0]);
            if (cfg_valid && cfg_ready)
            begin
                sb.write_reg(cfg_index, cfg_data);
                reg_writes <= reg_writes + 1;
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)
                || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stop the run if transfers cease for too long.
    initial
    begin
        @(posedge rst_n);
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Timeout after %0d cycles without a transfer.", STALL_LIMIT);
        $display("tb_top NOT OK");
        $finish;
    end

    // Result side: alternate stall and ready bursts unless the run is in its calm tail.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (calm)
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    // Present one sample and hold it until the transfer; valid stays high afterward.
    task automatic send_sample(input logic [RAW_W-1:0] raw);
        s_axis_tdata  <= {{(S_TDATA_W-RAW_W){1'b0}}, raw};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        prev_raw = raw;
    endtask

    task automatic pause_sender(input int unsigned cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Hold off input until all queued commands are out, then let the block settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; the caller lowers valid after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PULSE_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_pulses(input logic [PULSE_W-1:0] lo_us, input logic [PULSE_W-1:0] hi_us);
        write_reg(REG_MIN_PULSE, lo_us);
        write_reg(REG_MAX_PULSE, hi_us);
        cfg_valid <= 1'b0;
    endtask

    // Random sample: wide jumps most often, with holds, extremes, the clamp point and small steps.
    function automatic logic [RAW_W-1:0] pick_raw(input logic [RAW_W-1:0] prev);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return RAW_W'($urandom_range(0, 4095));
            4, 5:       return prev;
            6:          return $urandom_range(0, 1) ? 12'd4095 : 12'd0;
            7:          return RAW_W'(POT_LIMIT + $urandom_range(0, 20) - 10);
            default:    return RAW_W'(32'(prev) + $urandom_range(0, 400) - 200);
        endcase
    endfunction

    logic [RAW_W-1:0] opening [24] = '{
        12'd0, 12'd0,
        12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
        12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
        12'd2730, 12'd2730, 12'd2731,
        12'd0, 12'd0, 12'd0, 12'd0, 12'd1,
        12'd4094, 12'd2048, 12'd2048, 12'd3000
    };

    // Pulse settings per phase: zero, saturating, swapped, full span, defaults, then random.
    logic [PULSE_W-1:0] phase_min [NUM_PHASES] = '{
        15'd0, 15'd20000, 15'd32767, 15'd2000, 15'd0, 15'd0, 15'd1000, 15'd0, 15'd0
    };
    logic [PULSE_W-1:0] phase_max [NUM_PHASES] = '{
        15'd0, 15'd20000, 15'd32767, 15'd1000, 15'd32767, 15'd20000, 15'd2000, 15'd0, 15'd0
    };

    // Main stimulus sequence.
    initial
    begin
        logic [PULSE_W-1:0] lo_us;
        logic [PULSE_W-1:0] hi_us;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening at reset pulse widths, with one full drain midway.
        foreach (opening[i])
        begin
            send_sample(opening[i]);
            if (i == 11)
                drain();
        end
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            lo_us = phase_min[p];
            hi_us = phase_max[p];
            if (p >= NUM_PHASES - 2)
            begin
                lo_us = PULSE_W'($urandom_range(0, 32767));
                hi_us = PULSE_W'($urandom_range(0, 32767));
            end
            if (p == 6)
            begin
                // Writes to unused indexes must not disturb the pulse widths.
                write_reg(REG_SPARE_A, PULSE_W'($urandom_range(0, 32767)));
                write_reg(REG_SPARE_B, PULSE_W'($urandom_range(0, 32767)));
            end
            set_pulses(lo_us, hi_us);

            calm  = (p == NUM_PHASES - 1);
            gappy = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (!calm && gappy && $urandom_range(0, 3) == 0)
                    pause_sender($urandom_range(1, 16));
                send_sample(pick_raw(prev_raw));
            end
            drain();
        end

        $display("Covered %0d samples, %0d servo commands, %0d register writes.",
                 sb.samples_seen, sb.cmds_checked, reg_writes);
        $display("Pulse settings included zero, swapped, saturating and full-span widths.");
        if (sb.mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// File: pot_to_servo_duty_mapper.f
+incdir+rtl/core
rtl/core/ptsd_pkg.sv
rtl/core/ptsd_mul.sv
rtl/core/pot_to_servo_duty_mapper.sv
tb/tb_top.sv
